// File: hw/rtl/swhsr_pkg.sv
// Package with the item types, register map and phase codes of the sensor reader.
package swhsr_pkg;

  localparam int CFG_W  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int FRAME_BITS = 40;
  localparam int COUNT_W = 6;

  localparam logic [2:0] REG_START_LOW    = 3'd0;
  localparam logic [2:0] REG_RELEASE_WAIT = 3'd1;
  localparam logic [2:0] REG_SAMPLE_DELAY = 3'd2;
  localparam logic [2:0] REG_TIMEOUT      = 3'd3;
  localparam logic [2:0] REG_TAIL         = 3'd4;

  localparam logic [CFG_W-1:0] RST_START_LOW    = 16'd18000;
  localparam logic [CFG_W-1:0] RST_RELEASE_WAIT = 16'd40;
  localparam logic [CFG_W-1:0] RST_SAMPLE_DELAY = 16'd30;
  localparam logic [CFG_W-1:0] RST_TIMEOUT      = 16'd255;
  localparam logic [CFG_W-1:0] RST_TAIL         = 16'd1000;

  localparam logic [COUNT_W-1:0] FRAME_COUNT = 6'd40;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_LOW = 4'd1,
    PH_RELEASE   = 4'd2,
    PH_RESP_LOW  = 4'd3,
    PH_RESP_HIGH = 4'd4,
    PH_BIT_RISE  = 4'd5,
    PH_BIT_DELAY = 4'd6,
    PH_BIT_FALL  = 4'd7,
    PH_TAIL      = 4'd8
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] channel;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       line_drive_low;
    logic [3:0] mux_select;
    logic       mux_enable;
    logic       busy_res;
    logic       reading_valid;
    logic       reading_error;
    logic [7:0] humidity;
    logic [7:0] temperature;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] start_low_ticks;
    logic [CFG_W-1:0] release_wait_ticks;
    logic [CFG_W-1:0] sample_delay_ticks;
    logic [CFG_W-1:0] timeout_ticks;
    logic [CFG_W-1:0] tail_ticks;
  } cfg_t;

endpackage

// File: hw/rtl/swhsr_regs.sv
// Configuration register file with its APB-style access port.
module swhsr_regs
  import swhsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_ticks    <= RST_START_LOW;
      cfg_r.release_wait_ticks <= RST_RELEASE_WAIT;
      cfg_r.sample_delay_ticks <= RST_SAMPLE_DELAY;
      cfg_r.timeout_ticks      <= RST_TIMEOUT;
      cfg_r.tail_ticks         <= RST_TAIL;
    end else if (wr_en) begin
      case (reg_idx)
        REG_START_LOW:    cfg_r.start_low_ticks    <= pwdata[CFG_W-1:0];
        REG_RELEASE_WAIT: cfg_r.release_wait_ticks <= pwdata[CFG_W-1:0];
        REG_SAMPLE_DELAY: cfg_r.sample_delay_ticks <= pwdata[CFG_W-1:0];
        REG_TIMEOUT:      cfg_r.timeout_ticks      <= pwdata[CFG_W-1:0];
        REG_TAIL:         cfg_r.tail_ticks         <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_LOW:    prdata = DATA_W'(cfg_r.start_low_ticks);
      REG_RELEASE_WAIT: prdata = DATA_W'(cfg_r.release_wait_ticks);
      REG_SAMPLE_DELAY: prdata = DATA_W'(cfg_r.sample_delay_ticks);
      REG_TIMEOUT:      prdata = DATA_W'(cfg_r.timeout_ticks);
      REG_TAIL:         prdata = DATA_W'(cfg_r.tail_ticks);
      default:          prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/single_wire_humidity_sensor_reader.sv
// Top level of the single-wire humidity and temperature sensor reader.
// The block takes one item per clock cycle while the output is not stalled and gives
// one result per item. An item is caught in an input register, passes once through
// the phase logic, which updates the reader state, and lands in a result register,
// where it is offered until it is taken. The input register and the result register
// each hold one item, so a new item is taken while a finished result waits.
// Timing is counted in items: tick items advance the wait timer, which is
// TIMER_BITS wide and saturates; register limits above its range are clipped.
module single_wire_humidity_sensor_reader
  import swhsr_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int LW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [LW-1:0] TMAX = LW'((64'd1 << TIMER_BITS) - 64'd1);

  cfg_t cfg;

  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      proc, in_acc;

  phase_t                phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] wait_timer_r, wait_timer_nxt;
  logic [COUNT_W-1:0]    bit_count_r, bit_count_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [3:0]            chan_r, chan_nxt;
  logic [7:0]            hum_r, hum_nxt;
  logic [7:0]            temp_r, temp_nxt;

  logic [TIMER_BITS-1:0] timer_inc;
  logic [LW-1:0]         timer_inc_x;
  logic                  ev_valid, ev_error, do_next;
  logic [7:0]            chk_sum;
  logic                  line;

  function automatic logic lim_done(input logic [LW-1:0] t, input logic [CFG_W-1:0] lim);
    logic [LW-1:0] l;
    l = LW'(lim);
    if (l > TMAX) l = TMAX;
    return t >= l;
  endfunction

  swhsr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign proc          = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall      = in_valid_r & ~proc;
  assign in_acc        = in_valid & ~in_stall;
  assign in_valid_nxt  = in_acc | (in_valid_r & ~proc);
  assign out_valid_nxt = proc | (out_valid_r & out_stall);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  assign line        = in_data_r.line_level;
  assign timer_inc   = (wait_timer_r == {TIMER_BITS{1'b1}}) ? wait_timer_r
                                                             : wait_timer_r + 1'b1;
  assign timer_inc_x = LW'(timer_inc);

  always_comb begin
    phase_nxt      = phase_r;
    wait_timer_nxt = wait_timer_r;
    bit_count_nxt  = bit_count_r;
    frame_nxt      = frame_r;
    chan_nxt       = chan_r;
    hum_nxt        = hum_r;
    temp_nxt       = temp_r;
    ev_valid       = 1'b0;
    ev_error       = 1'b0;
    do_next        = 1'b0;
    chk_sum        = '0;
    if (proc) begin
      if (in_data_r.kind) begin
        if (phase_r == PH_IDLE) begin
          chan_nxt       = in_data_r.channel;
          bit_count_nxt  = '0;
          frame_nxt      = '0;
          phase_nxt      = PH_START_LOW;
          wait_timer_nxt = '0;
        end
      end else begin
        case (phase_r)
          PH_START_LOW: begin
            wait_timer_nxt = timer_inc;
            if (lim_done(timer_inc_x, cfg.start_low_ticks)) begin
              phase_nxt      = PH_RELEASE;
              wait_timer_nxt = '0;
            end
          end
          PH_RELEASE: begin
            wait_timer_nxt = timer_inc;
            if (lim_done(timer_inc_x, cfg.release_wait_ticks)) begin
              wait_timer_nxt = '0;
              if (line) begin
                phase_nxt = PH_IDLE;
                ev_error  = 1'b1;
              end else begin
                phase_nxt = PH_RESP_LOW;
              end
            end
          end
          PH_RESP_LOW: begin
            if (line) begin
              phase_nxt      = PH_RESP_HIGH;
              wait_timer_nxt = '0;
            end else begin
              wait_timer_nxt = timer_inc;
              if (lim_done(timer_inc_x, cfg.timeout_ticks)) begin
                phase_nxt      = PH_IDLE;
                wait_timer_nxt = '0;
                ev_error       = 1'b1;
              end
            end
          end
          PH_RESP_HIGH: begin
            if (!line) begin
              bit_count_nxt  = '0;
              frame_nxt      = '0;
              phase_nxt      = PH_BIT_RISE;
              wait_timer_nxt = '0;
            end else begin
              wait_timer_nxt = timer_inc;
              if (lim_done(timer_inc_x, cfg.timeout_ticks)) begin
                phase_nxt      = PH_IDLE;
                wait_timer_nxt = '0;
                ev_error       = 1'b1;
              end
            end
          end
          PH_BIT_RISE: begin
            if (line) begin
              phase_nxt      = PH_BIT_DELAY;
              wait_timer_nxt = '0;
            end else begin
              wait_timer_nxt = timer_inc;
              if (lim_done(timer_inc_x, cfg.timeout_ticks)) begin
                phase_nxt      = PH_BIT_DELAY;
                wait_timer_nxt = '0;
              end
            end
          end
          PH_BIT_DELAY: begin
            wait_timer_nxt = timer_inc;
            if (lim_done(timer_inc_x, cfg.sample_delay_ticks)) begin
              frame_nxt     = {frame_r[FRAME_BITS-2:0], line};
              bit_count_nxt = bit_count_r + 1'b1;
              if (line) begin
                phase_nxt      = PH_BIT_FALL;
                wait_timer_nxt = '0;
              end else begin
                do_next = 1'b1;
              end
            end
          end
          PH_BIT_FALL: begin
            if (!line) begin
              do_next = 1'b1;
            end else begin
              wait_timer_nxt = timer_inc;
              if (lim_done(timer_inc_x, cfg.timeout_ticks)) do_next = 1'b1;
            end
          end
          PH_TAIL: begin
            wait_timer_nxt = timer_inc;
            if (lim_done(timer_inc_x, cfg.tail_ticks)) begin
              phase_nxt      = PH_IDLE;
              wait_timer_nxt = '0;
            end
          end
          default: ;
        endcase
        chk_sum = frame_nxt[39:32] + frame_nxt[31:24] + frame_nxt[23:16] + frame_nxt[15:8];
        if (do_next) begin
          wait_timer_nxt = '0;
          if (bit_count_nxt < FRAME_COUNT) begin
            phase_nxt = PH_BIT_RISE;
          end else if (chk_sum != frame_nxt[7:0]) begin
            phase_nxt = PH_IDLE;
            ev_error  = 1'b1;
          end else begin
            hum_nxt   = frame_nxt[39:32];
            temp_nxt  = frame_nxt[23:16];
            phase_nxt = (cfg.tail_ticks == '0) ? PH_IDLE : PH_TAIL;
            ev_valid  = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    out_data_nxt.line_drive_low = (phase_nxt == PH_START_LOW);
    out_data_nxt.mux_select     = chan_nxt;
    out_data_nxt.mux_enable     = (phase_nxt != PH_IDLE);
    out_data_nxt.busy_res       = (phase_nxt != PH_IDLE);
    out_data_nxt.reading_valid  = ev_valid;
    out_data_nxt.reading_error  = ev_error;
    out_data_nxt.humidity       = hum_nxt;
    out_data_nxt.temperature    = temp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_IDLE;
      wait_timer_r <= '0;
      bit_count_r  <= '0;
      frame_r      <= '0;
      chan_r       <= '0;
      hum_r        <= '0;
      temp_r       <= '0;
    end else begin
      in_valid_r   <= in_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      phase_r      <= phase_nxt;
      wait_timer_r <= wait_timer_nxt;
      bit_count_r  <= bit_count_nxt;
      frame_r      <= frame_nxt;
      chan_r       <= chan_nxt;
      hum_r        <= hum_nxt;
      temp_r       <= temp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) in_data_r <= in_data;
    if (proc)   out_data_r <= out_data_nxt;
  end

endmodule

// File: tb/sv/reading_check_pkg.sv
// Predictor and result checker for the single-wire sensor reader testbench.
`timescale 1ns / 100ps
package reading_check_pkg;
  import swhsr_pkg::*;

  localparam logic [15:0] TIMER_TOP = 16'hFFFF;
  localparam int REPORT_LIMIT = 50;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_GOOD,
    EV_FAIL
  } reading_event_e;

  class reading_checker;
    logic [CFG_W-1:0] start_low, rel_wait, sample_dly, timeout, tail;
    phase_t ph;
    logic [15:0] wait_timer;
    logic [COUNT_W-1:0] bit_count;
    logic [FRAME_BITS-1:0] frame;
    logic [3:0] chan;
    logic [7:0] hum, temp;
    out_item_t due_reports[$];
    int mismatches;
    int good_readings;

    function void reset_state();
      start_low = RST_START_LOW;
      rel_wait = RST_RELEASE_WAIT;
      sample_dly = RST_SAMPLE_DELAY;
      timeout = RST_TIMEOUT;
      tail = RST_TAIL;
      ph = PH_IDLE;
      wait_timer = '0;
      bit_count = '0;
      frame = '0;
      chan = '0;
      hum = '0;
      temp = '0;
      mismatches = 0;
      good_readings = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_START_LOW: start_low = v;
        REG_RELEASE_WAIT: rel_wait = v;
        REG_SAMPLE_DELAY: sample_dly = v;
        REG_TIMEOUT: timeout = v;
        REG_TAIL: tail = v;
        default: ;
      endcase
    endfunction

    // The timer saturates; a limit of zero is reached on the first tick.
    function bit count_done(logic [CFG_W-1:0] limit);
      if (wait_timer != TIMER_TOP) wait_timer++;
      return wait_timer >= limit;
    endfunction

    function void move_to(phase_t p);
      ph = p;
      wait_timer = '0;
    endfunction

    function reading_event_e end_of_bit();
      logic [7:0] sum;
      if (bit_count < FRAME_COUNT) begin
        move_to(PH_BIT_RISE);
        return EV_NONE;
      end
      sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
      if (sum != frame[7:0]) begin
        move_to(PH_IDLE);
        return EV_FAIL;
      end
      hum = frame[39:32];
      temp = frame[23:16];
      move_to(tail == '0 ? PH_IDLE : PH_TAIL);
      return EV_GOOD;
    endfunction

    function void take_command(in_item_t it);
      reading_event_e ev;
      out_item_t want;
      ev = EV_NONE;
      if (it.kind) begin
        if (ph == PH_IDLE) begin
          chan = it.channel;
          bit_count = '0;
          frame = '0;
          move_to(PH_START_LOW);
        end
      end else begin
        case (ph)
          PH_START_LOW: if (count_done(start_low)) move_to(PH_RELEASE);
          PH_RELEASE: begin
            if (count_done(rel_wait)) begin
              if (it.line_level) begin
                move_to(PH_IDLE);
                ev = EV_FAIL;
              end else begin
                move_to(PH_RESP_LOW);
              end
            end
          end
          PH_RESP_LOW: begin
            if (it.line_level) begin
              move_to(PH_RESP_HIGH);
            end else if (count_done(timeout)) begin
              move_to(PH_IDLE);
              ev = EV_FAIL;
            end
          end
          PH_RESP_HIGH: begin
            if (!it.line_level) begin
              bit_count = '0;
              frame = '0;
              move_to(PH_BIT_RISE);
            end else if (count_done(timeout)) begin
              move_to(PH_IDLE);
              ev = EV_FAIL;
            end
          end
          PH_BIT_RISE: if (it.line_level || count_done(timeout)) move_to(PH_BIT_DELAY);
          PH_BIT_DELAY: begin
            if (count_done(sample_dly)) begin
              frame = {frame[FRAME_BITS-2:0], it.line_level};
              bit_count++;
              if (it.line_level) move_to(PH_BIT_FALL);
              else ev = end_of_bit();
            end
          end
          PH_BIT_FALL: if (!it.line_level || count_done(timeout)) ev = end_of_bit();
          PH_TAIL: if (count_done(tail)) move_to(PH_IDLE);
          default: ;
        endcase
      end
      if (ev == EV_GOOD) good_readings++;
      want = '0;
      want.line_drive_low = (ph == PH_START_LOW);
      want.mux_select = chan;
      want.mux_enable = (ph != PH_IDLE);
      want.busy_res = (ph != PH_IDLE);
      want.reading_valid = (ev == EV_GOOD);
      want.reading_error = (ev == EV_FAIL);
      want.humidity = hum;
      want.temperature = temp;
      due_reports.push_back(want);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
        mismatches++;
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (due_reports.size() == 0) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("%0t: result %0h arrived with none expected", $time, got);
        end
        mismatches++;
        return;
      end
      want = due_reports.pop_front();
      compare_field("line_drive_low", want.line_drive_low, got.line_drive_low);
      compare_field("mux_select", want.mux_select, got.mux_select);
      compare_field("mux_enable", want.mux_enable, got.mux_enable);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("reading_valid", want.reading_valid, got.reading_valid);
      compare_field("reading_error", want.reading_error, got.reading_error);
      compare_field("humidity", want.humidity, got.humidity);
      compare_field("temperature", want.temperature, got.temperature);
    endfunction
  endclass

endpackage

// File: tb/sv/single_wire_humidity_sensor_reader_tb.sv
// Top-level testbench that drives the sensor reader and checks every result transfer.
`timescale 1ns / 100ps
module single_wire_humidity_sensor_reader_tb;
  import swhsr_pkg::*;
  import reading_check_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  reading_checker tracker;
  logic [FRAME_BITS-1:0] frame_word = '0;
  bit quick = 1'b0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  int n_out = 0;
  int idle_cycles = 0;

  single_wire_humidity_sensor_reader u_top (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("single_wire_humidity_sensor_reader: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int w;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (n_out == HOLD_AT) w = HOLD_CYCLES;
      else if (quick || recv_burst) w = 0;
      else w = $urandom_range(0, 7);
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.check_report(out_data);
      n_out++;
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    gap = (quick || send_burst) ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.take_command(it);
    @(negedge clk);
  endtask

  function automatic logic sensor_level();
    case (tracker.ph)
      PH_RELEASE: return quick ? 1'b0 : ($urandom_range(0, 15) == 0);
      PH_RESP_LOW: return $urandom_range(0, 2) == 0;
      PH_RESP_HIGH: return $urandom_range(0, 2) != 0;
      PH_BIT_RISE: return $urandom_range(0, 3) != 0;
      PH_BIT_DELAY: return frame_word[FRAME_BITS-1-int'(tracker.bit_count)]
                           ^ (!quick && $urandom_range(0, 63) == 0);
      PH_BIT_FALL: return $urandom_range(0, 3) == 0;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic in_item_t next_command();
    in_item_t it;
    if (tracker.ph == PH_IDLE) it.kind = ($urandom_range(0, 2) == 0);
    else it.kind = ($urandom_range(0, 15) == 0);
    it.channel = 4'($urandom_range(0, 15));
    it.line_level = it.kind ? 1'($urandom_range(0, 1)) : sensor_level();
    if (it.kind && tracker.ph == PH_IDLE) begin
      frame_word[39:8] = $urandom;
      frame_word[7:0] = frame_word[39:32] + frame_word[31:24] + frame_word[23:16]
                        + frame_word[15:8];
      if (!quick && $urandom_range(0, 7) == 0) begin
        frame_word[7:0] ^= 8'($urandom_range(1, 255));
      end
    end
    return it;
  endfunction

  task automatic bus_write(input logic [2:0] idx, input logic [CFG_W-1:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic verify_reg(input logic [2:0] idx, input logic [CFG_W-1:0] want);
    logic [DATA_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (got !== DATA_W'(want)) begin
      $display("%0t: register %0d expected %0h, got %0h", $time, idx, want, got);
      tracker.mismatches++;
    end
  endtask

  task automatic program_reg(input logic [2:0] idx, input logic [CFG_W-1:0] v);
    bus_write(idx, v);
    tracker.set_reg(idx, v);
    verify_reg(idx, v);
  endtask

  task automatic program_all(input logic [CFG_W-1:0] sl, rw, sd, to, tl);
    program_reg(REG_START_LOW, sl);
    program_reg(REG_RELEASE_WAIT, rw);
    program_reg(REG_SAMPLE_DELAY, sd);
    program_reg(REG_TIMEOUT, to);
    program_reg(REG_TAIL, tl);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.due_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] sl, rw, sd, to, tl,
                           input int min_items, min_good, cap);
    int n_items;
    int good0;
    in_item_t it;
    n_items = 0;
    good0 = tracker.good_readings;
    program_all(sl, rw, sd, to, tl);
    while ((n_items < min_items || tracker.good_readings - good0 < min_good)
           && n_items < cap) begin
      it = next_command();
      if ((tracker.ph != PH_IDLE) != it.kind) n_items++;
      send_item(it);
    end
    while (tracker.ph != PH_IDLE) send_item(next_command());
    settle();
  endtask

  initial begin
    in_item_t script [17] = '{
      '{1'b0, 4'd0, 1'b0}, '{1'b0, 4'd15, 1'b1}, '{1'b1, 4'd15, 1'b0},
      '{1'b1, 4'd5, 1'b1}, '{1'b0, 4'd0, 1'b0}, '{1'b0, 4'd3, 1'b1},
      '{1'b1, 4'd0, 1'b1}, '{1'b0, 4'd0, 1'b1}, '{1'b0, 4'd0, 1'b0},
      '{1'b0, 4'd0, 1'b0}, '{1'b0, 4'd0, 1'b0}, '{1'b1, 4'd9, 1'b0},
      '{1'b0, 4'd0, 1'b0}, '{1'b0, 4'd0, 1'b0}, '{1'b0, 4'd0, 1'b1},
      '{1'b0, 4'd0, 1'b1}, '{1'b0, 4'd0, 1'b1}
    };
    tracker = new;
    tracker.reset_state();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    verify_reg(REG_START_LOW, RST_START_LOW);
    verify_reg(REG_RELEASE_WAIT, RST_RELEASE_WAIT);
    verify_reg(REG_SAMPLE_DELAY, RST_SAMPLE_DELAY);
    verify_reg(REG_TIMEOUT, RST_TIMEOUT);
    verify_reg(REG_TAIL, RST_TAIL);

    program_all(16'd1, 16'd1, 16'd1, 16'd2, 16'd0);
    foreach (script[i]) send_item(script[i]);
    settle();

    run_phase(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 200, 1, 2000);
    repeat (2) begin
      run_phase(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                16'($urandom_range(1, 3)), 16'($urandom_range(1, 8)),
                16'($urandom_range(0, 6)), 200, 1, 2000);
    end

    // Longer limits: one full reading with no idling on either side.
    quick = 1'b1;
    run_phase(16'd40, 16'd40, 16'd1, 16'd40, 16'd40, 0, 1, 2000);
    quick = 1'b0;

    repeat (8) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.due_reports.size() == 0) begin
      $display("single_wire_humidity_sensor_reader: match");
    end else begin
      $display("single_wire_humidity_sensor_reader: mismatch");
    end
    $finish;
  end

endmodule
